@@ rtl/vlad_pkg.sv @@
// vlad_pkg: shared types, status codes and lead-byte classification
// for the variable-length address decoder. No dependencies.
`default_nettype none
package vlad_pkg;

    localparam int AddrW = 64;
    localparam int LenW  = 4;
    localparam int StW   = 3;

    localparam logic [StW-1:0] ST_OK      = 3'd0;
    localparam logic [StW-1:0] ST_BAD_LEAD = 3'd1;
    localparam logic [StW-1:0] ST_LOW_2B  = 3'd2;
    localparam logic [StW-1:0] ST_LOW_3B  = 3'd3;
    localparam logic [StW-1:0] ST_LOW_5B  = 3'd4;
    localparam logic [StW-1:0] ST_LOW_7B  = 3'd5;

    localparam logic [7:0] EIGHT_LEAD_RST = 8'hFE;

    // One finished address handed from the front to the back.
    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic [LenW-1:0]  len;
        logic             bad;
    } vlad_rec_t;

    // Address length selected by a lead byte, 0 for an unknown lead.
    function automatic logic [LenW-1:0] lead_length(input logic [7:0] lead,
                                                    input logic [7:0] eight_lead);
        logic [LenW-1:0] len;
        begin
            if (lead <= 8'hDC)
                len = 4'd1;
            else if (lead <= 8'hF0 || lead == 8'hFF)
                len = 4'd2;
            else if (lead == 8'hF1)
                len = 4'd3;
            else if (lead == 8'hF2)
                len = 4'd5;
            else if (lead == 8'hF3)
                len = 4'd7;
            else if (lead == eight_lead)
                len = 4'd8;
            else
                len = 4'd0;
            return len;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/variable_length_address_decoder.sv @@
// variable_length_address_decoder: top level of the address decoder.
// Depends on vlad_pkg, vlad_front, vlad_fifo and vlad_back.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  tdata: data_byte; tuser: start_of_address
//  m_*       out  m_tvalid / m_tready  tdata: addr_bytes, addr_size, status;
//                                      tuser: is_public, is_any, is_local
//  cfg_*     in   cfg_valid/cfg_ready  cfg_data: eight_byte_lead
//
// One byte per cycle is accepted while the queue is not full. A result passes
// from the front into a queue entry, then into the back output register.
// Input stalls only when the two-entry queue is full, i.e. when the result
// side has been held off. Reset clears the gather state,
// the queue and the output valid, and loads eight_byte_lead with 0xFE.
// Config writes are always taken (cfg_ready tied high).
`default_nettype none
module variable_length_address_decoder import vlad_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] start_of_address
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [71:0] m_tdata,   // [63:0] addr_bytes, [67:64] addr_size,
                                        // [70:68] status, [71] zero
    output      logic [2:0]  m_tuser,   // [0] is_public, [1] is_any, [2] is_local
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [7:0]  cfg_data   // eight_byte_lead
);

    logic             in_acc;
    logic             push, pop, full, not_empty;
    vlad_rec_t        push_rec, head;
    logic [AddrW-1:0] addr_bytes;
    logic [LenW-1:0]  addr_size;
    logic [StW-1:0]   status;
    logic             is_public, is_any, is_local;

    assign cfg_ready = 1'b1;
    // Ready depends only on queue occupancy, never on s_tvalid.
    assign s_tready  = !full;
    assign in_acc    = s_tvalid && s_tready;

    vlad_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid),
        .cfg_data         (cfg_data),
        .in_acc           (in_acc),
        .data_byte        (s_tdata),
        .start_of_address (s_tuser[0]),
        .push             (push),
        .push_rec         (push_rec)
    );

    vlad_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    vlad_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (not_empty),
        .rec        (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .addr_bytes (addr_bytes),
        .addr_size  (addr_size),
        .status     (status),
        .is_public  (is_public),
        .is_any     (is_any),
        .is_local   (is_local)
    );

    assign m_tdata = {1'b0, status, addr_size, addr_bytes};
    assign m_tuser = {is_local, is_any, is_public};

endmodule
`default_nettype wire

@@ rtl/vlad_front.sv @@
// vlad_front: accepts header bytes, classifies lead bytes and gathers
// address bytes; pushes one record per finished address. Uses vlad_pkg.
`default_nettype none
module vlad_front import vlad_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [7:0]      cfg_data,
    input  wire logic            in_acc,
    input  wire logic [7:0]      data_byte,
    input  wire logic            start_of_address,
    output      logic            push,
    output      vlad_rec_t       push_rec
);

    logic [7:0]       eight_lead_reg;
    logic [AddrW-1:0] gathered_reg, gathered_next;
    logic [LenW-1:0]  seen_reg, seen_next;
    logic [LenW-1:0]  exp_reg, exp_next;
    logic             collecting_reg, collecting_next;
    logic [LenW-1:0]  lead_len;
    logic [AddrW-1:0] merged;
    logic [LenW-1:0]  seen_inc;

    assign lead_len = lead_length(data_byte, eight_lead_reg);
    assign seen_inc = seen_reg + 4'd1;

    // Drop the new byte into the lane picked by the byte count.
    always_comb
    begin
        merged = gathered_reg;
        for (int k = 1; k < 8; k++)
        begin
            if (seen_reg[2:0] == 3'(k))
                merged[AddrW-1-8*k -: 8] = data_byte;
        end
    end

    always_comb
    begin
        gathered_next   = gathered_reg;
        seen_next       = seen_reg;
        exp_next        = exp_reg;
        collecting_next = collecting_reg;
        push            = 1'b0;
        push_rec.addr   = merged;
        push_rec.len    = exp_reg;
        push_rec.bad    = 1'b0;
        if (in_acc)
        begin
            if (start_of_address)
            begin
                gathered_next = {data_byte, {(AddrW-8){1'b0}}};
                seen_next     = 4'd1;
                exp_next      = lead_len;
                push_rec.addr = {data_byte, {(AddrW-8){1'b0}}};
                push_rec.len  = lead_len;
                if (lead_len == 4'd0)
                begin
                    collecting_next = 1'b0;
                    push            = 1'b1;
                    push_rec.addr   = '0;
                    push_rec.bad    = 1'b1;
                end
                else if (lead_len == 4'd1)
                begin
                    collecting_next = 1'b0;
                    push            = 1'b1;
                end
                else
                begin
                    collecting_next = 1'b1;
                end
            end
            else if (collecting_reg)
            begin
                gathered_next = merged;
                seen_next     = seen_inc;
                if (seen_inc >= exp_reg)
                begin
                    collecting_next = 1'b0;
                    push            = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eight_lead_reg <= EIGHT_LEAD_RST;
            seen_reg       <= '0;
            exp_reg        <= '0;
            collecting_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                eight_lead_reg <= cfg_data;
            seen_reg       <= seen_next;
            exp_reg        <= exp_next;
            collecting_reg <= collecting_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gathered_reg <= gathered_next;
    end

endmodule
`default_nettype wire

@@ rtl/vlad_fifo.sv @@
// vlad_fifo: two-entry record queue between front and back.
// Uses vlad_pkg for the record type.
`default_nettype none
module vlad_fifo import vlad_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire vlad_rec_t push_rec,
    input  wire logic      pop,
    output      logic      full,
    output      logic      not_empty,
    output      vlad_rec_t head
);

    vlad_rec_t  ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_rec;
    end

endmodule
`default_nettype wire

@@ rtl/vlad_back.sv @@
// vlad_back: range checks and flag decode on finished addresses, with
// the output register of the result channel. Uses vlad_pkg.
`default_nettype none
module vlad_back import vlad_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rec_valid,
    input  wire vlad_rec_t        rec,
    output      logic             pop,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      logic [AddrW-1:0] addr_bytes,
    output      logic [LenW-1:0]  addr_size,
    output      logic [StW-1:0]   status,
    output      logic             is_public,
    output      logic             is_any,
    output      logic             is_local
);

    logic             valid_reg;
    logic [AddrW-1:0] addr_reg;
    logic [LenW-1:0]  len_reg;
    logic [StW-1:0]   st_reg, st_next;
    logic             pub_reg, any_reg, loc_reg;
    logic [7:0]       b0, b1, b2;
    logic             two, pub_next;

    assign b0       = rec.addr[63:56];
    assign b1       = rec.addr[55:48];
    assign b2       = rec.addr[47:40];
    assign two      = (rec.len == 4'd2);
    assign pub_next = two && (b0 == 8'hFF);

    always_comb
    begin
        st_next = ST_OK;
        if (rec.bad)
            st_next = ST_BAD_LEAD;
        else if (two && b0 != 8'hFF)
        begin
            if (!(b0 > 8'hDD || b1 >= 8'hDD))
                st_next = ST_LOW_2B;
        end
        else if (rec.len == 4'd3)
        begin
            if (b1 < 8'h14)
                st_next = ST_LOW_3B;
        end
        else if (rec.len == 4'd5)
        begin
            if (b1 == 8'h00 && b2 == 8'h00)
                st_next = ST_LOW_5B;
        end
        else if (rec.len == 4'd7)
        begin
            if (b1 == 8'h00 && b2 == 8'h00)
                st_next = ST_LOW_7B;
        end
    end

    assign pop = rec_valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg <= rec.addr;
            len_reg  <= rec.len;
            st_reg   <= st_next;
            pub_reg  <= pub_next;
            any_reg  <= pub_next && (b1 == 8'h09);
            loc_reg  <= pub_next && (b1 == 8'h00);
        end
    end

    assign out_valid  = valid_reg;
    assign addr_bytes = addr_reg;
    assign addr_size  = len_reg;
    assign status     = st_reg;
    assign is_public  = pub_reg;
    assign is_any     = any_reg;
    assign is_local   = loc_reg;

endmodule
`default_nettype wire

@@ tb/tb_variable_length_address_decoder.sv @@
// Self-checking testbench for variable_length_address_decoder: directed and random
// header byte streams, checked against an in-bench decoder image. Needs vlad_pkg.
`timescale 1ns / 100ps

module tb_variable_length_address_decoder;
    import vlad_pkg::*;

    localparam int QUIET_LIMIT = 2000;    // cycles without any handshake
    localparam int RANDOM_BYTES = 1250;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic [0:0]  s_tuser;    // [0] start_of_address
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;    // [63:0] addr_bytes, [67:64] addr_size, [70:68] status, [71] zero
    logic [2:0]  m_tuser;    // [0] is_public, [1] is_any, [2] is_local
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    typedef struct {
        logic [63:0] addr;
        logic [3:0]  len;
        logic [2:0]  status;
        logic        is_public;
        logic        is_any;
        logic        is_local;
    } addr_result_t;

    // Decoded addresses waiting to come out, oldest first.
    addr_result_t expected_addrs[$];

    // Image of the decoder state.
    logic [63:0] addr_acc;
    logic [3:0]  bytes_in;
    logic [3:0]  len_wanted;
    logic        gathering;
    logic [7:0]  eight_lead;

    int err_count = 0;
    int bytes_used = 0;      // bytes that the decoder acted on
    int quiet_cycles = 0;
    bit sender_pauses = 1;
    bit sink_pauses = 1;

    variable_length_address_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Decoder image
    // ---------------------------------------------------------------

    // Length chosen by a lead byte under the current register value.
    function automatic logic [3:0] lead_bytes(input logic [7:0] lead);
        if (lead <= 8'hDC)
            return 4'd1;
        if (lead <= 8'hF0 || lead == 8'hFF)
            return 4'd2;
        case (lead)
            8'hF1:   return 4'd3;
            8'hF2:   return 4'd5;
            8'hF3:   return 4'd7;
            default: return (lead == eight_lead) ? 4'd8 : 4'd0;
        endcase
    endfunction

    // Range rules and flags for the address now gathered.
    function automatic addr_result_t finish_addr();
        addr_result_t r;
        logic [7:0]   b0;
        logic [7:0]   b1;
        logic [7:0]   b2;
        logic         two;
        b0 = addr_acc[63:56];
        b1 = addr_acc[55:48];
        b2 = addr_acc[47:40];
        two = (len_wanted == 4'd2);
        r.addr = addr_acc;
        r.len = len_wanted;
        r.status = ST_OK;
        if (two && b0 != 8'hFF)
        begin
            if (b0 <= 8'hDD && b1 < 8'hDD)
                r.status = ST_LOW_2B;
        end
        else if (len_wanted == 4'd3)
        begin
            if (b1 < 8'h14)
                r.status = ST_LOW_3B;
        end
        else if (len_wanted == 4'd5)
        begin
            if (b1 == 8'h00 && b2 == 8'h00)
                r.status = ST_LOW_5B;
        end
        else if (len_wanted == 4'd7)
        begin
            if (b1 == 8'h00 && b2 == 8'h00)
                r.status = ST_LOW_7B;
        end
        r.is_public = two && b0 == 8'hFF;
        r.is_any = r.is_public && b1 == 8'h09;
        r.is_local = r.is_public && b1 == 8'h00;
        return r;
    endfunction

    // Advance the image by one accepted byte; used is 0 if the byte was ignored.
    task automatic decode_byte(input logic [7:0] b, input logic start, output bit used);
        logic [3:0]   len;
        addr_result_t r;
        used = 1;
        if (start)
        begin
            len = lead_bytes(b);
            addr_acc = {b, 56'h0};
            bytes_in = 4'd1;
            len_wanted = len;
            if (len == 4'd0)
            begin
                // unknown lead: error item at once
                gathering = 1'b0;
                addr_acc = '0;
                bytes_in = '0;
                r.addr = '0;
                r.len = '0;
                r.status = ST_BAD_LEAD;
                r.is_public = 1'b0;
                r.is_any = 1'b0;
                r.is_local = 1'b0;
                expected_addrs.push_back(r);
            end
            else if (len == 4'd1)
            begin
                gathering = 1'b0;
                expected_addrs.push_back(finish_addr());
            end
            else
                gathering = 1'b1;
        end
        else if (!gathering)
            used = 0;
        else
        begin
            if (bytes_in >= 4'd1 && bytes_in <= 4'd7)
                addr_acc = addr_acc | (64'(b) << (56 - 8 * bytes_in));
            bytes_in = bytes_in + 4'd1;
            if (bytes_in >= len_wanted)
            begin
                gathering = 1'b0;
                expected_addrs.push_back(finish_addr());
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= 40)
            $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin : result_check
        addr_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_addrs.size() == 0)
                report_mismatch("unexpected item", m_tdata[63:0], 64'h0);
            else
            begin
                want = expected_addrs.pop_front();
                if (m_tdata[63:0] !== want.addr)
                    report_mismatch("addr_bytes", m_tdata[63:0], want.addr);
                if (m_tdata[67:64] !== want.len)
                    report_mismatch("addr_size", 64'(m_tdata[67:64]), 64'(want.len));
                if (m_tdata[70:68] !== want.status)
                    report_mismatch("status", 64'(m_tdata[70:68]), 64'(want.status));
                if (m_tdata[71] !== 1'b0)
                    report_mismatch("tdata pad", 64'(m_tdata[71]), 64'h0);
                if (m_tuser[0] !== want.is_public)
                    report_mismatch("is_public", 64'(m_tuser[0]), 64'(want.is_public));
                if (m_tuser[1] !== want.is_any)
                    report_mismatch("is_any", 64'(m_tuser[1]), 64'(want.is_any));
                if (m_tuser[2] !== want.is_local)
                    report_mismatch("is_local", 64'(m_tuser[2]), 64'(want.is_local));
            end
        end
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_variable_length_address_decoder: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stalls per item, with stretches of none.
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                sink_pauses = !sink_pauses;
            stall = sink_pauses ? $urandom_range(0, 18) : 0;
            if (stall != 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers (called and returning at a falling edge)
    // ---------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        bit used;
        gap = sender_pauses ? $urandom_range(0, 18) : 0;
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata = b;
        s_tuser = start;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_byte(b, start, used);
        if (used)
            bytes_used++;
        @(negedge clk);
    endtask

    // First n bytes of hdr, top byte first, the first one marked as lead.
    task automatic send_addr(input logic [63:0] hdr, input int n);
        for (int i = 0; i < n; i++)
            send_byte(hdr[63 - 8 * i -: 8], i == 0);
    endtask

    // Drain the decoder before touching the register.
    task automatic settle();
        s_tvalid = 1'b0;
        while (expected_addrs.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_eight_lead(input logic [7:0] val);
        settle();
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        eight_lead = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] content_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'($urandom_range(0, 8'h20));
            2:       return 8'($urandom_range(8'hD8, 8'hE0));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One address of random form; some are cut short, some are plain noise.
    task automatic send_random_address();
        int          pick;
        int          n;
        logic [7:0]  lead;
        logic [63:0] hdr;
        if ($urandom_range(0, 15) == 0)
            sender_pauses = !sender_pauses;
        pick = $urandom_range(0, 19);
        case (pick)
            0, 1, 2:    lead = 8'($urandom_range(0, 8'hDC));
            3, 4:       lead = 8'($urandom_range(8'hDD, 8'hF0));
            5:          lead = 8'hDD;
            6:          lead = 8'hFF;
            7, 8:       lead = 8'hF1;
            9, 10:      lead = 8'hF2;
            11, 12:     lead = 8'hF3;
            13, 14, 15: lead = eight_lead;
            16:         lead = 8'($urandom_range(8'hF4, 8'hFE));
            default:    lead = 8'($urandom_range(0, 255));
        endcase
        if (pick == 17)
        begin
            // stray bytes with no lead mark
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        if (pick == 19)
        begin
            send_byte(lead, 1'($urandom_range(0, 1)));
            return;
        end
        hdr = {lead, 56'h0};
        for (int i = 1; i < 8; i++)
            hdr[63 - 8 * i -: 8] = content_byte();
        if (lead == 8'hFF)
            case ($urandom_range(0, 2))
                0:       hdr[55:48] = 8'h00;
                1:       hdr[55:48] = 8'h09;
                default: ;
            endcase
        n = lead_bytes(lead);
        if (n == 0)
            n = 1;
        if (pick == 18 && n > 1)
            n = $urandom_range(1, n - 1);   // partial, dropped by the next lead
        send_addr(hdr, n);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_one_byte_leads();
        send_addr(64'h0000_0000_0000_0000, 1);
        send_addr(64'hDC00_0000_0000_0000, 1);
        send_addr(64'h5A00_0000_0000_0000, 1);
        send_addr(64'hA500_0000_0000_0000, 1);
    endtask

    task automatic test_two_byte_forms();
        send_addr(64'hDD00_0000_0000_0000, 2);   // below range
        send_addr(64'hDDDC_0000_0000_0000, 2);   // just below
        send_addr(64'hDDDD_0000_0000_0000, 2);   // lowest valid
        send_addr(64'hDE00_0000_0000_0000, 2);
        send_addr(64'hF0FF_0000_0000_0000, 2);
        send_addr(64'hFF09_0000_0000_0000, 2);   // any
        send_addr(64'hFF00_0000_0000_0000, 2);   // local
        send_addr(64'hFF80_0000_0000_0000, 2);   // public only
    endtask

    task automatic test_long_forms();
        send_addr(64'hF113_FF00_0000_0000, 3);   // below range
        send_addr(64'hF114_0000_0000_0000, 3);
        send_addr(64'hF200_00FF_FF00_0000, 5);   // below range
        send_addr(64'hF200_0100_0000_0000, 5);
        send_addr(64'hF300_0000_0000_FF00, 7);   // below range
        send_addr(64'hF301_0000_0000_0000, 7);
    endtask

    task automatic test_eight_and_bad_leads();
        send_addr(64'hFE01_0203_0405_0607, 8);
        send_addr(64'hF400_0000_0000_0000, 1);   // unknown lead
        send_addr(64'hFD00_0000_0000_0000, 1);
    endtask

    task automatic test_idle_and_restart();
        send_byte(8'h00, 1'b0);                  // ignored while idle
        send_byte(8'hFF, 1'b0);
        send_addr(64'hF211_0000_0000_0000, 2);   // cut short by the next lead
        send_addr(64'h0500_0000_0000_0000, 1);
        send_addr(64'hF100_0000_0000_0000, 1);   // cut short again
        send_addr(64'hF3AA_5566_7788_9900, 7);
    endtask

    task automatic test_lead_register();
        write_eight_lead(8'hF4);
        send_addr(64'hF4FF_EEDD_CCBB_AA99, 8);
        send_addr(64'hFE00_0000_0000_0000, 1);   // no longer a lead
        write_eight_lead(8'hFE);
        send_addr(64'hFE00_0000_0000_0000, 8);
        write_eight_lead(8'hF1);                 // earlier rule wins
        send_addr(64'hF120_0000_0000_0000, 3);
        write_eight_lead(8'hFF);
        send_addr(64'hFF01_0000_0000_0000, 2);
        write_eight_lead(8'h0B);
        send_addr(64'h0B00_0000_0000_0000, 1);
        send_addr(64'hF500_0000_0000_0000, 1);
    endtask

    task automatic test_random_traffic();
        int base;
        base = bytes_used;
        for (int phase = 0; phase < 10; phase++)
        begin
            if ($urandom_range(0, 4) == 0)
                write_eight_lead(8'($urandom_range(0, 255)));
            else
                write_eight_lead(8'($urandom_range(8'hF4, 8'hFE)));
            while (bytes_used < base + (phase + 1) * (RANDOM_BYTES / 10))
                send_random_address();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        eight_lead = 8'hFE;
        addr_acc = '0;
        bytes_in = '0;
        len_wanted = '0;
        gathering = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_one_byte_leads();
        test_two_byte_forms();
        test_long_forms();
        test_eight_and_bad_leads();
        test_idle_and_restart();
        test_lead_register();
        test_random_traffic();

        s_tvalid = 1'b0;
        while (expected_addrs.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (err_count == 0)
            $display("tb_variable_length_address_decoder: clean");
        else
            $display("tb_variable_length_address_decoder: errors");
        $finish;
    end

endmodule
